>>> src/apnd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the aspect-preserving nearest downscaler.
package apnd_pkg;

    localparam int DIM_W     = 13;
    localparam int FRAC_W    = 16;
    localparam int STEP_W    = DIM_W + FRAC_W;
    localparam int ACC_W     = STEP_W + 1;
    localparam int PIX_W     = 32;
    localparam int MAX_DIM   = 4096;
    localparam int DIV_STEPS = STEP_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);
    localparam int IDX_W     = 2;

    localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_MAX_EDGE   = IDX_W'(2);

    typedef logic [DIM_W-1:0]  dim_t;
    typedef logic [STEP_W-1:0] step_t;
    typedef logic [ACC_W-1:0]  acc_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PLAN,
        ST_DIM,
        ST_XINIT,
        ST_XDIV,
        ST_YINIT,
        ST_YDIV,
        ST_READY
    } setup_state_t;

    typedef struct packed {
        logic  ready;
        dim_t  src_w;
        dim_t  src_h;
        dim_t  dest_w;
        dim_t  dest_h;
        step_t step_x;
        step_t step_y;
    } geom_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             row_end;
        logic             frame_end;
    } result_t;

    function automatic dim_t clamp_dim(input dim_t v);
        dim_t r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > DIM_W'(MAX_DIM))
        begin
            r = DIM_W'(MAX_DIM);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

>>> src/apnd_setup.sv
`timescale 1ns / 1ps
// Configuration registers and frame geometry sequencer with a shared serial divider.
module apnd_setup (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [apnd_pkg::IDX_W-1:0] cfg_index,
    input  apnd_pkg::dim_t           cfg_data,
    output apnd_pkg::geom_t          geom
);

    apnd_pkg::dim_t         src_width_reg;
    apnd_pkg::dim_t         src_height_reg;
    apnd_pkg::dim_t         max_edge_reg;

    apnd_pkg::setup_state_t state_reg, state_next;
    apnd_pkg::dim_t         sw_reg, sw_next;
    apnd_pkg::dim_t         sh_reg, sh_next;
    apnd_pkg::dim_t         me_reg, me_next;
    logic                   wide_reg, wide_next;
    apnd_pkg::dim_t         dw_reg, dw_next;
    apnd_pkg::dim_t         dh_reg, dh_next;
    apnd_pkg::step_t        stx_reg, stx_next;
    apnd_pkg::step_t        sty_reg, sty_next;
    apnd_pkg::step_t        num_reg, num_next;
    apnd_pkg::dim_t         rem_reg, rem_next;
    apnd_pkg::dim_t         den_reg, den_next;
    logic [apnd_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    logic [apnd_pkg::DIM_W:0]     trial;
    logic                         ge;
    apnd_pkg::dim_t               rem_step;
    apnd_pkg::step_t              num_step;
    logic                         last_step;
    logic                         fits;
    logic                         wide;
    apnd_pkg::dim_t               mul_a;
    logic [2*apnd_pkg::DIM_W-1:0] prod;
    apnd_pkg::dim_t               quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= apnd_pkg::DIM_W'(1);
            src_height_reg <= apnd_pkg::DIM_W'(1);
            max_edge_reg   <= apnd_pkg::DIM_W'(128);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                apnd_pkg::REG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                apnd_pkg::REG_SRC_HEIGHT: src_height_reg <= cfg_data;
                apnd_pkg::REG_MAX_EDGE:   max_edge_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= apnd_pkg::ST_LOAD;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sw_reg   <= sw_next;
        sh_reg   <= sh_next;
        me_reg   <= me_next;
        wide_reg <= wide_next;
        dw_reg   <= dw_next;
        dh_reg   <= dh_next;
        stx_reg  <= stx_next;
        sty_reg  <= sty_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    always_comb
    begin
        trial     = {rem_reg, num_reg[apnd_pkg::STEP_W-1]};
        ge        = trial >= {1'b0, den_reg};
        rem_step  = ge ? apnd_pkg::DIM_W'(trial - {1'b0, den_reg})
                       : trial[apnd_pkg::DIM_W-1:0];
        num_step  = {num_reg[apnd_pkg::STEP_W-2:0], ge};
        last_step = cnt_reg == apnd_pkg::CNT_W'(apnd_pkg::DIV_STEPS - 1);
        quot      = (num_step[apnd_pkg::DIM_W-1:0] == '0) ? apnd_pkg::DIM_W'(1)
                                                          : num_step[apnd_pkg::DIM_W-1:0];
        fits      = (sw_reg <= me_reg) && (sh_reg <= me_reg);
        wide      = sw_reg > sh_reg;
        mul_a     = wide ? sh_reg : sw_reg;
        prod      = mul_a * me_reg;

        state_next = state_reg;
        sw_next    = sw_reg;
        sh_next    = sh_reg;
        me_next    = me_reg;
        wide_next  = wide_reg;
        dw_next    = dw_reg;
        dh_next    = dh_reg;
        stx_next   = stx_reg;
        sty_next   = sty_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        cnt_next   = cnt_reg;

        unique case (state_reg)
            apnd_pkg::ST_LOAD:
            begin
                sw_next    = apnd_pkg::clamp_dim(src_width_reg);
                sh_next    = apnd_pkg::clamp_dim(src_height_reg);
                me_next    = apnd_pkg::clamp_dim(max_edge_reg);
                state_next = apnd_pkg::ST_PLAN;
            end
            apnd_pkg::ST_PLAN:
            begin
                wide_next = wide;
                rem_next  = '0;
                cnt_next  = '0;
                num_next  = apnd_pkg::STEP_W'(prod);
                if (fits)
                begin
                    dw_next    = sw_reg;
                    dh_next    = sh_reg;
                    state_next = apnd_pkg::ST_XINIT;
                end
                else if (wide)
                begin
                    dw_next    = me_reg;
                    den_next   = sw_reg;
                    state_next = apnd_pkg::ST_DIM;
                end
                else
                begin
                    dh_next    = me_reg;
                    den_next   = sh_reg;
                    state_next = apnd_pkg::ST_DIM;
                end
            end
            apnd_pkg::ST_DIM:
            begin
                rem_next = rem_step;
                num_next = num_step;
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                begin
                    if (wide_reg)
                    begin
                        dh_next = quot;
                    end
                    else
                    begin
                        dw_next = quot;
                    end
                    state_next = apnd_pkg::ST_XINIT;
                end
            end
            apnd_pkg::ST_XINIT:
            begin
                num_next   = {sw_reg, apnd_pkg::FRAC_W'(0)};
                den_next   = dw_reg;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = apnd_pkg::ST_XDIV;
            end
            apnd_pkg::ST_XDIV:
            begin
                rem_next = rem_step;
                num_next = num_step;
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                begin
                    stx_next   = num_step;
                    state_next = apnd_pkg::ST_YINIT;
                end
            end
            apnd_pkg::ST_YINIT:
            begin
                num_next   = {sh_reg, apnd_pkg::FRAC_W'(0)};
                den_next   = dh_reg;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = apnd_pkg::ST_YDIV;
            end
            apnd_pkg::ST_YDIV:
            begin
                rem_next = rem_step;
                num_next = num_step;
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                begin
                    sty_next   = num_step;
                    state_next = apnd_pkg::ST_READY;
                end
            end
            apnd_pkg::ST_READY:
            begin
            end
        endcase

        // restart on any register write
        if (cfg_we)
        begin
            state_next = apnd_pkg::ST_LOAD;
        end
    end

    always_comb
    begin
        geom.ready  = state_reg == apnd_pkg::ST_READY;
        geom.src_w  = sw_reg;
        geom.src_h  = sh_reg;
        geom.dest_w = dw_reg;
        geom.dest_h = dh_reg;
        geom.step_x = stx_reg;
        geom.step_y = sty_reg;
    end

endmodule

>>> src/apnd_front.sv
`timescale 1ns / 1ps
// Source position tracking and nearest-neighbor pick of each incoming pixel.
module apnd_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [apnd_pkg::PIX_W-1:0]  pixel_in,
    input  logic                        clear,
    input  apnd_pkg::geom_t             geom,
    output logic                        res_we,
    output apnd_pkg::result_t           res
);

    apnd_pkg::dim_t src_col_reg, src_col_next;
    apnd_pkg::dim_t src_row_reg, src_row_next;
    apnd_pkg::dim_t dest_col_reg, dest_col_next;
    apnd_pkg::dim_t dest_row_reg, dest_row_next;
    apnd_pkg::acc_t acc_x_reg, acc_x_next;
    apnd_pkg::acc_t acc_y_reg, acc_y_next;

    logic row_hit;
    logic col_hit;
    logic last_col;
    logic last_row;
    logic src_row_done;
    logic src_frame_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg  <= '0;
            src_row_reg  <= '0;
            dest_col_reg <= '0;
            dest_row_reg <= '0;
            acc_x_reg    <= '0;
            acc_y_reg    <= '0;
        end
        else
        begin
            src_col_reg  <= src_col_next;
            src_row_reg  <= src_row_next;
            dest_col_reg <= dest_col_next;
            dest_row_reg <= dest_row_next;
            acc_x_reg    <= acc_x_next;
            acc_y_reg    <= acc_y_next;
        end
    end

    always_comb
    begin
        row_hit = (dest_row_reg < geom.dest_h)
                  && ({1'b0, src_row_reg} == acc_y_reg[apnd_pkg::ACC_W-1:apnd_pkg::FRAC_W]);
        col_hit = row_hit && (dest_col_reg < geom.dest_w)
                  && ({1'b0, src_col_reg} == acc_x_reg[apnd_pkg::ACC_W-1:apnd_pkg::FRAC_W]);
        last_col = ({1'b0, dest_col_reg} + 1'b1) == {1'b0, geom.dest_w};
        last_row = ({1'b0, dest_row_reg} + 1'b1) == {1'b0, geom.dest_h};
        src_row_done   = ({1'b0, src_col_reg} + 1'b1) >= {1'b0, geom.src_w};
        src_frame_done = ({1'b0, src_row_reg} + 1'b1) >= {1'b0, geom.src_h};

        res_we        = accept && col_hit;
        res.pixel     = pixel_in;
        res.row_end   = last_col;
        res.frame_end = last_col && last_row;

        src_col_next  = src_col_reg;
        src_row_next  = src_row_reg;
        dest_col_next = dest_col_reg;
        dest_row_next = dest_row_reg;
        acc_x_next    = acc_x_reg;
        acc_y_next    = acc_y_reg;

        if (clear)
        begin
            src_col_next  = '0;
            src_row_next  = '0;
            dest_col_next = '0;
            dest_row_next = '0;
            acc_x_next    = '0;
            acc_y_next    = '0;
        end
        else if (accept)
        begin
            if (src_row_done)
            begin
                src_col_next  = '0;
                dest_col_next = '0;
                acc_x_next    = '0;
                if (src_frame_done)
                begin
                    src_row_next  = '0;
                    dest_row_next = '0;
                    acc_y_next    = '0;
                end
                else
                begin
                    src_row_next = src_row_reg + 1'b1;
                    if (row_hit)
                    begin
                        dest_row_next = dest_row_reg + 1'b1;
                        acc_y_next    = acc_y_reg + apnd_pkg::ACC_W'(geom.step_y);
                    end
                end
            end
            else
            begin
                src_col_next = src_col_reg + 1'b1;
                if (col_hit)
                begin
                    dest_col_next = dest_col_reg + 1'b1;
                    acc_x_next    = acc_x_reg + apnd_pkg::ACC_W'(geom.step_x);
                end
            end
        end
    end

endmodule

>>> src/apnd_queue.sv
`timescale 1ns / 1ps
// Result queue between the pick logic and the output side.
module apnd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  apnd_pkg::result_t wr_data,
    input  logic              rd_en,
    output apnd_pkg::result_t rd_data,
    output logic              empty,
    output logic              full
);

    apnd_pkg::result_t            mem [apnd_pkg::Q_DEPTH];
    logic [apnd_pkg::Q_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [apnd_pkg::Q_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [apnd_pkg::Q_AW:0]      count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_comb
    begin
        empty       = count_reg == '0;
        full        = count_reg == (apnd_pkg::Q_AW + 1)'(apnd_pkg::Q_DEPTH);
        rd_data     = mem[rd_ptr_reg];
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

endmodule

>>> src/aspect_preserving_nearest_downscaler_top.sv
`timescale 1ns / 1ps
// Top level of the aspect-preserving nearest-neighbor downscaler.
//
// Source pixels enter in raster order through push/full, one per cycle in steady state;
// each pixel that is the nearest pick for the next destination column and row is
// written to a four-beat result queue read through empty/pop, marked with row_end and
// frame_end. Destination size and 13.16 step ratios are computed after reset and after
// every register write by a sequencer with one shared restoring divider that retires
// one quotient bit per cycle; full stays high while that runs, while cfg_valid is high,
// and whenever the queue holds four beats. A register write abandons the current frame,
// and the next pixel starts a new one.
module aspect_preserving_nearest_downscaler_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [apnd_pkg::PIX_W-1:0]   pixel_in,
    output logic                         empty,
    input  logic                         pop,
    output logic [apnd_pkg::PIX_W-1:0]   pixel_out,
    output logic                         row_end,
    output logic                         frame_end,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [apnd_pkg::IDX_W-1:0]   cfg_index,
    input  logic [apnd_pkg::DIM_W-1:0]   cfg_data
);

    apnd_pkg::geom_t   geom;
    apnd_pkg::result_t front_res;
    apnd_pkg::result_t head;
    logic              front_we;
    logic              cfg_we;
    logic              in_accept;
    logic              out_accept;
    logic              q_full;

    assign cfg_ready  = 1'b1;
    assign cfg_we     = cfg_valid && cfg_ready;
    assign full       = !geom.ready || q_full || cfg_valid;
    assign in_accept  = push && !full;
    assign out_accept = pop && !empty;
    assign pixel_out  = head.pixel;
    assign row_end    = head.row_end;
    assign frame_end  = head.frame_end;

    apnd_setup u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    apnd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (in_accept),
        .pixel_in (pixel_in),
        .clear    (cfg_we),
        .geom     (geom),
        .res_we   (front_we),
        .res      (front_res)
    );

    apnd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_we),
        .wr_data (front_res),
        .rd_en   (out_accept),
        .rd_data (head),
        .empty   (empty),
        .full    (q_full)
    );

endmodule

>>> src/apnd_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the downscaler and their binding to the top level.
module apnd_port_checks (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       push,
    input logic                       full,
    input logic                       empty,
    input logic                       pop,
    input logic [apnd_pkg::PIX_W-1:0] pixel_out,
    input logic                       row_end,
    input logic                       frame_end,
    input logic                       cfg_valid,
    input logic                       cfg_ready
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(pixel_out) && $stable(row_end)
                           && $stable(frame_end))
        else $error("waiting result beat changed or vanished");

    a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (!frame_end || row_end))
        else $error("frame_end without row_end");

    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> full)
        else $error("input open right after register write");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        empty && !(push && !full) |=> empty)
        else $error("result appeared without an input beat");

endmodule

bind aspect_preserving_nearest_downscaler_top apnd_port_checks u_port_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .pixel_out (pixel_out),
    .row_end   (row_end),
    .frame_end (frame_end),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

>>> test/apnd_checker.sv
`timescale 1ns / 1ps
// Scoreboard that predicts which source pixels the downscaler picks and checks every result beat.
module apnd_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic                       full,
    input  logic [apnd_pkg::PIX_W-1:0] pixel_in,
    input  logic                       empty,
    input  logic                       pop,
    input  logic [apnd_pkg::PIX_W-1:0] pixel_out,
    input  logic                       row_end,
    input  logic                       frame_end,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [apnd_pkg::IDX_W-1:0] cfg_index,
    input  logic [apnd_pkg::DIM_W-1:0] cfg_data,
    output int                         errors,
    output int                         waiting
);

    apnd_pkg::dim_t    reg_w;
    apnd_pkg::dim_t    reg_h;
    apnd_pkg::dim_t    reg_me;
    apnd_pkg::dim_t    out_w;
    apnd_pkg::dim_t    out_h;
    apnd_pkg::dim_t    col;
    apnd_pkg::dim_t    row;
    apnd_pkg::dim_t    dcol;
    apnd_pkg::dim_t    drow;
    apnd_pkg::step_t   stride_x;
    apnd_pkg::step_t   stride_y;
    apnd_pkg::acc_t    pos_x;
    apnd_pkg::acc_t    pos_y;
    logic              in_frame;
    apnd_pkg::result_t due_pixels[$];

    function automatic int unsigned fit_edge(input apnd_pkg::dim_t v);
        int unsigned r;
        r = v;
        if (v == '0)
        begin
            r = 1;
        end
        else if (v > apnd_pkg::MAX_DIM)
        begin
            r = apnd_pkg::MAX_DIM;
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        errors++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task automatic plan_frame();
        longint unsigned sw;
        longint unsigned sh;
        longint unsigned me;
        longint unsigned dw;
        longint unsigned dh;
        sw = fit_edge(reg_w);
        sh = fit_edge(reg_h);
        me = fit_edge(reg_me);
        if (sw <= me && sh <= me)
        begin
            dw = sw;
            dh = sh;
        end
        else if (sw > sh)
        begin
            dw = me;
            dh = (sh * me) / sw;
        end
        else
        begin
            dh = me;
            dw = (sw * me) / sh;
        end
        if (dw == 0)
        begin
            dw = 1;
        end
        if (dh == 0)
        begin
            dh = 1;
        end
        out_w    = apnd_pkg::dim_t'(dw);
        out_h    = apnd_pkg::dim_t'(dh);
        stride_x = apnd_pkg::step_t'((sw << apnd_pkg::FRAC_W) / dw);
        stride_y = apnd_pkg::step_t'((sh << apnd_pkg::FRAC_W) / dh);
        col      = '0;
        row      = '0;
        dcol     = '0;
        drow     = '0;
        pos_x    = '0;
        pos_y    = '0;
        in_frame = 1'b1;
    endtask

    task automatic take_source_pixel(input logic [apnd_pkg::PIX_W-1:0] px);
        int unsigned       sw;
        int unsigned       sh;
        logic              row_hit;
        logic              last_col;
        apnd_pkg::result_t pick;
        if (!in_frame)
        begin
            plan_frame();
        end
        sw = fit_edge(reg_w);
        sh = fit_edge(reg_h);
        row_hit = (drow < out_h) && (row == (pos_y >> apnd_pkg::FRAC_W));
        if (row_hit && dcol < out_w && col == (pos_x >> apnd_pkg::FRAC_W))
        begin
            last_col       = (dcol + 1 == out_w);
            pick.pixel     = px;
            pick.row_end   = last_col;
            pick.frame_end = last_col && (drow + 1 == out_h);
            due_pixels.push_back(pick);
            dcol  = dcol + 1'b1;
            pos_x = pos_x + stride_x;
        end
        if (col + 1 >= sw)
        begin
            if (row_hit)
            begin
                drow  = drow + 1'b1;
                pos_y = pos_y + stride_y;
            end
            dcol  = '0;
            pos_x = '0;
            col   = '0;
            if (row + 1 >= sh)
            begin
                row      = '0;
                in_frame = 1'b0;
            end
            else
            begin
                row = row + 1'b1;
            end
        end
        else
        begin
            col = col + 1'b1;
        end
    endtask

    task automatic check_beat();
        apnd_pkg::result_t want;
        if (due_pixels.size() == 0)
        begin
            flag_mismatch($sformatf("unexpected beat, pixel %h", pixel_out));
        end
        else
        begin
            want = due_pixels.pop_front();
            if (pixel_out !== want.pixel)
            begin
                flag_mismatch($sformatf("pixel_out %h, want %h", pixel_out, want.pixel));
            end
            if (row_end !== want.row_end)
            begin
                flag_mismatch($sformatf("row_end %b, want %b (pixel %h)",
                                        row_end, want.row_end, want.pixel));
            end
            if (frame_end !== want.frame_end)
            begin
                flag_mismatch($sformatf("frame_end %b, want %b (pixel %h)",
                                        frame_end, want.frame_end, want.pixel));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reg_w    = apnd_pkg::DIM_W'(1);
            reg_h    = apnd_pkg::DIM_W'(1);
            reg_me   = apnd_pkg::DIM_W'(128);
            out_w    = '0;
            out_h    = '0;
            stride_x = '0;
            stride_y = '0;
            col      = '0;
            row      = '0;
            dcol     = '0;
            drow     = '0;
            pos_x    = '0;
            pos_y    = '0;
            in_frame = 1'b0;
            due_pixels.delete();
            errors   = 0;
            waiting  = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                check_beat();
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    apnd_pkg::REG_SRC_WIDTH:  reg_w  = cfg_data;
                    apnd_pkg::REG_SRC_HEIGHT: reg_h  = cfg_data;
                    apnd_pkg::REG_MAX_EDGE:   reg_me = cfg_data;
                    default: ;
                endcase
                in_frame = 1'b0;
            end
            if (push && !full)
            begin
                take_source_pixel(pixel_in);
            end
            waiting = due_pixels.size();
        end
    end

endmodule

>>> test/tb_aspect_preserving_nearest_downscaler_top.sv
`timescale 1ns / 1ps
// Testbench top: drives pixel frames and register settings into the downscaler and reports the verdict.
module tb_aspect_preserving_nearest_downscaler_top;

    localparam logic [apnd_pkg::IDX_W-1:0] REG_UNMAPPED = apnd_pkg::IDX_W'(3);
    localparam int SETTLE      = 100;
    localparam int PIXEL_GOAL  = 1950;

    logic                       clk;
    logic                       rst_n;
    logic                       push;
    logic                       full;
    logic [apnd_pkg::PIX_W-1:0] pixel_in;
    logic                       empty;
    logic                       pop;
    logic [apnd_pkg::PIX_W-1:0] pixel_out;
    logic                       row_end;
    logic                       frame_end;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [apnd_pkg::IDX_W-1:0] cfg_index;
    apnd_pkg::dim_t             cfg_data;
    int                         errors;
    int                         waiting;
    int                         send_idle  = 0;
    int                         recv_stall = 0;
    int                         sent       = 0;
    apnd_pkg::dim_t             cur_w;
    apnd_pkg::dim_t             cur_h;

    aspect_preserving_nearest_downscaler_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pixel_in  (pixel_in),
        .empty     (empty),
        .pop       (pop),
        .pixel_out (pixel_out),
        .row_end   (row_end),
        .frame_end (frame_end),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    apnd_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pixel_in  (pixel_in),
        .empty     (empty),
        .pop       (pop),
        .pixel_out (pixel_out),
        .row_end   (row_end),
        .frame_end (frame_end),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .waiting   (waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            pop <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    // leaves cfg_valid high; caller drops it after the last write
    task automatic write_reg(input logic [apnd_pkg::IDX_W-1:0] idx, input apnd_pkg::dim_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == apnd_pkg::REG_SRC_WIDTH)
        begin
            cur_w = val;
        end
        else if (idx == apnd_pkg::REG_SRC_HEIGHT)
        begin
            cur_h = val;
        end
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic send_pixel(input logic [apnd_pkg::PIX_W-1:0] px);
        while ($urandom_range(0, 99) < send_idle)
        begin
            push     <= 1'b0;
            pixel_in <= $urandom();
            @(negedge clk);
        end
        push     <= 1'b1;
        pixel_in <= px;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        sent++;
    endtask

    task automatic drain();
        push <= 1'b0;
        while (waiting != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    function automatic apnd_pkg::dim_t pick_dim(input int hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            return '0;
        end
        if (r < 8)
        begin
            return apnd_pkg::DIM_W'(apnd_pkg::MAX_DIM);
        end
        if (r < 12)
        begin
            return apnd_pkg::DIM_W'($urandom_range(apnd_pkg::MAX_DIM + 1, 8191));
        end
        if (r < 16)
        begin
            return apnd_pkg::DIM_W'($urandom());
        end
        if (r < 20)
        begin
            return apnd_pkg::DIM_W'(1);
        end
        return apnd_pkg::DIM_W'($urandom_range(1, hi));
    endfunction

    initial
    begin
        int phase;
        int fw;
        int fh;
        int count;
        rst_n     = 1'b0;
        push      = 1'b0;
        pixel_in  = '0;
        cfg_valid = 1'b0;
        cfg_index = apnd_pkg::REG_SRC_WIDTH;
        cfg_data  = '0;
        cur_w     = apnd_pkg::DIM_W'(1);
        cur_h     = apnd_pkg::DIM_W'(1);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // one-pixel frames at reset defaults
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h5A5A_A5A5);
        drain();

        // downscale with trailing rows that pick nothing
        write_reg(apnd_pkg::REG_SRC_WIDTH, apnd_pkg::DIM_W'(4));
        write_reg(apnd_pkg::REG_SRC_HEIGHT, apnd_pkg::DIM_W'(3));
        write_reg(apnd_pkg::REG_MAX_EDGE, apnd_pkg::DIM_W'(2));
        cfg_valid <= 1'b0;
        repeat (12) send_pixel($urandom());
        drain();

        // out-of-range registers, frame left unfinished
        write_reg(apnd_pkg::REG_SRC_WIDTH, '0);
        write_reg(apnd_pkg::REG_SRC_HEIGHT, apnd_pkg::DIM_W'(8191));
        write_reg(apnd_pkg::REG_MAX_EDGE, '0);
        cfg_valid <= 1'b0;
        repeat (5) send_pixel($urandom());
        drain();

        // unmapped index aborts the frame
        write_reg(REG_UNMAPPED, apnd_pkg::DIM_W'(13'h1555));
        cfg_valid <= 1'b0;
        repeat (3) send_pixel($urandom());
        drain();

        phase = 0;
        while (sent < PIXEL_GOAL)
        begin
            unique case (phase % 4)
                0:
                begin
                    send_idle  = 0;
                    recv_stall = 0;
                end
                1:
                begin
                    send_idle  = 70;
                    recv_stall = 0;
                end
                2:
                begin
                    send_idle  = 0;
                    recv_stall = 70;
                end
                default:
                begin
                    send_idle  = 12;
                    recv_stall = 12;
                end
            endcase
            if ($urandom_range(0, 9) < 7)
            begin
                write_reg(apnd_pkg::REG_SRC_WIDTH, pick_dim(20));
            end
            if ($urandom_range(0, 9) < 7)
            begin
                write_reg(apnd_pkg::REG_SRC_HEIGHT, pick_dim(20));
            end
            if ($urandom_range(0, 9) < 6)
            begin
                write_reg(apnd_pkg::REG_MAX_EDGE, pick_dim(12));
            end
            if ($urandom_range(0, 9) == 0)
            begin
                write_reg(REG_UNMAPPED, apnd_pkg::DIM_W'($urandom()));
            end
            cfg_valid <= 1'b0;
            fw = (cur_w == '0) ? 1
                 : ((cur_w > apnd_pkg::MAX_DIM) ? apnd_pkg::MAX_DIM : cur_w);
            fh = (cur_h == '0) ? 1
                 : ((cur_h > apnd_pkg::MAX_DIM) ? apnd_pkg::MAX_DIM : cur_h);
            if (fw * fh <= 400)
            begin
                count = fw * fh * $urandom_range(1, 3);
                if (fw * fh > 1 && $urandom_range(0, 4) == 0)
                begin
                    count += $urandom_range(1, fw * fh - 1);
                end
            end
            else
            begin
                count = $urandom_range(20, 150);
            end
            if (count > PIXEL_GOAL - sent)
            begin
                count = PIXEL_GOAL - sent;
            end
            repeat (count) send_pixel($urandom());
            drain();
            phase++;
        end

        recv_stall = 0;
        drain();
        if (errors == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
